[hw/rtl/chm_pkg.sv]
// Package for the chained hash map: item structs, operation codes,
// state enums and the mixer constants. No dependencies.

package chm_pkg;

    typedef enum logic [1:0] {
        KIND_PUT    = 2'd0,
        KIND_GET    = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } chm_kind_t;

    typedef struct packed {
        chm_kind_t   kind;
        logic [63:0] key;
        logic [63:0] value;
    } chm_req_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] found_value;
        logic [8:0]  entry_total;
    } chm_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_CMP,
        S_RESOLVE,
        S_ALLOC,
        S_LINK,
        S_LINK2,
        S_DONE
    } chm_state_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_MUL,
        H_DIV
    } chm_hstate_t;

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int          MIX_S1 = 30;
    localparam int          MIX_S2 = 27;
    localparam int          MIX_S3 = 31;
    localparam int          CFG_W  = 7;
    localparam logic [CFG_W-1:0] DIVISOR_RESET = 7'd64;

endpackage

[hw/rtl/chm_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.

module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/chm_hash.sv]
// Bucket hash unit: splitmix64 finalizer on one shared 32x32 multiplier,
// then a bit-serial restoring remainder by the bucket count. Uses chm_pkg.

module chm_hash
    import chm_pkg::*;
#(
    parameter int BUCKETS = 64
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  logic [63:0]                                  key,
    input  logic [$clog2(BUCKETS+1)-1:0]                 divisor,
    output logic                                         done,
    output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] bucket
);

    localparam int DW = $clog2(BUCKETS + 1);
    localparam int BW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;

    chm_hstate_t      state_reg, state_next;
    logic [63:0]      x_reg;
    logic [63:0]      acc_reg;
    logic [63:0]      prod_reg;
    logic             round_reg;
    logic [1:0]       step_reg;
    logic [31:0]      num_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    div_reg;
    logic [4:0]       cnt_reg;
    logic             done_reg;

    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      cmul;
    logic [63:0]      prod_next;
    logic [63:0]      acc_new;
    logic [63:0]      fin;
    logic [DW:0]      trial;
    logic             fits;
    logic [DW-1:0]    rem_next;

    assign cmul      = round_reg ? MIX_C2 : MIX_C1;
    assign mul_a     = (step_reg == 2'd2) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b     = (step_reg == 2'd1) ? cmul[63:32] : cmul[31:0];
    assign prod_next = mul_a * mul_b;
    assign acc_new   = (step_reg == 2'd1) ? prod_reg
                     : {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
    assign fin       = acc_new ^ (acc_new >> MIX_S3);
    assign trial     = {rem_reg, num_reg[31]};
    assign fits      = trial >= {1'b0, div_reg};
    assign rem_next  = fits ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];

    assign done   = done_reg;
    assign bucket = rem_reg[BW-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    state_next = H_MUL;
                end
            end
            H_MUL:
            begin
                if (step_reg == 2'd3 && round_reg)
                begin
                    state_next = H_DIV;
                end
            end
            H_DIV:
            begin
                if (cnt_reg == 5'd31)
                begin
                    state_next = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == H_DIV) && (cnt_reg == 5'd31);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            H_IDLE:
            begin
                x_reg     <= key ^ (key >> MIX_S1);
                div_reg   <= divisor;
                round_reg <= 1'b0;
                step_reg  <= 2'd0;
            end
            H_MUL:
            begin
                prod_reg <= prod_next;
                step_reg <= step_reg + 2'd1;
                if (step_reg != 2'd0)
                begin
                    acc_reg <= acc_new;
                end
                if (step_reg == 2'd3)
                begin
                    round_reg <= 1'b1;
                    x_reg     <= acc_new ^ (acc_new >> MIX_S2);
                    num_reg   <= fin[31:0];
                    rem_reg   <= '0;
                    cnt_reg   <= 5'd0;
                end
            end
            H_DIV:
            begin
                rem_reg <= rem_next;
                num_reg <= {num_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
            end
            default:
            begin
                step_reg <= 2'd0;
            end
        endcase
    end

endmodule

[hw/rtl/chained_hash_map_unit.sv]
// Chained hash map top level: sequencer, chain walk, pool stack and
// response register. Uses chm_pkg, chm_hash and chm_ram.
//
//  channel  | handshake             | payload
//  req      | req_valid / req_stall | req  (chm_req_t: kind, key, value)
//  rsp      | rsp_valid / rsp_stall | rsp  (chm_rsp_t: ok, found_value, entry_total)
//  cfg      | cfg_we                | cfg_data (bucket divisor)
//
// Put, get and remove run the hash (shared multiplier, then 32-step
// remainder) and walk the chain; a put of a new key also allocates and
// links an entry. Clear skips the hash. req_stall is high while an item
// is in work; the next item is taken while a response still waits.
// Reset empties all chains and the pool at once; no sweep is needed.

module chained_hash_map_unit
    import chm_pkg::*;
#(
    parameter int BUCKETS = 64,
    parameter int ENTRIES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  chm_req_t         req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output chm_rsp_t         rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int DW = $clog2(BUCKETS + 1);
    localparam int BW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
    localparam int LW = $clog2(ENTRIES + 1);
    localparam int IW = $clog2(ENTRIES);
    localparam logic [LW-1:0] LINK_END = LW'(ENTRIES);

    chm_state_t       state_reg, state_next;
    logic [CFG_W-1:0] bcount_reg;
    chm_kind_t        kind_reg;
    logic [63:0]      key_reg;
    logic [63:0]      value_reg;
    logic [BW-1:0]    bucket_reg;
    logic [LW-1:0]    cur_reg;
    logic [LW-1:0]    prev_reg;
    logic [LW-1:0]    nx_reg;
    logic [IW-1:0]    e_reg;
    logic             hit_reg;
    logic             ok_reg;
    logic [63:0]      got_reg;
    logic [LW-1:0]    used_reg;
    logic             head_valid_reg [BUCKETS];
    logic             free_valid_reg [ENTRIES];
    logic             rsp_valid_reg;
    chm_rsp_t         rsp_reg;

    logic             accept;
    logic             rsp_free;
    logic [DW-1:0]    divisor;
    logic             hash_done;
    logic [BW-1:0]    hash_bucket;
    logic [LW-1:0]    head_rdata;
    logic [LW-1:0]    head_cur;
    logic [LW-1:0]    walk_cur;
    logic [63:0]      key_rdata;
    logic [63:0]      value_rdata;
    logic [LW-1:0]    next_rdata;
    logic [IW-1:0]    free_rdata;
    logic [IW-1:0]    e_comb;
    logic             key_match;
    logic             rm_hit;
    logic [31:0]      used_wide;

    logic             head_we;
    logic [LW-1:0]    head_wdata;
    logic             ent_re;
    logic             kv_we;
    logic             val_we;
    logic [IW-1:0]    val_waddr;
    logic             next_we;
    logic [IW-1:0]    next_waddr;
    logic [LW-1:0]    next_wdata;
    logic             free_we;
    logic [IW-1:0]    free_waddr;

    assign accept    = req_valid && !req_stall;
    assign req_stall = state_reg != S_IDLE;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign divisor = (bcount_reg == '0) ? DW'(1)
                   : ((32'(bcount_reg) > BUCKETS) ? DW'(BUCKETS) : DW'(bcount_reg));

    assign head_cur  = head_valid_reg[bucket_reg] ? head_rdata : LINK_END;
    assign walk_cur  = (state_reg == S_HEAD) ? head_cur : next_rdata;
    assign key_match = key_rdata == key_reg;
    assign e_comb    = free_valid_reg[used_reg[IW-1:0]] ? free_rdata : used_reg[IW-1:0];
    assign rm_hit    = (state_reg == S_RESOLVE) && (kind_reg == KIND_REMOVE) && hit_reg;
    assign used_wide = 32'(used_reg);

    chm_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && (req.kind != KIND_CLEAR)),
        .key     (req.key),
        .divisor (divisor),
        .done    (hash_done),
        .bucket  (hash_bucket)
    );

    chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (bucket_reg),
        .wdata (head_wdata),
        .re    (hash_done),
        .raddr (hash_bucket),
        .rdata (head_rdata)
    );

    chm_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (kv_we),
        .waddr (e_comb),
        .wdata (key_reg),
        .re    (ent_re),
        .raddr (walk_cur[IW-1:0]),
        .rdata (key_rdata)
    );

    chm_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (value_reg),
        .re    (ent_re),
        .raddr (walk_cur[IW-1:0]),
        .rdata (value_rdata)
    );

    chm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (ent_re),
        .raddr (walk_cur[IW-1:0]),
        .rdata (next_rdata)
    );

    chm_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (cur_reg[IW-1:0]),
        .re    (state_reg == S_ALLOC),
        .raddr (used_reg[IW-1:0]),
        .rdata (free_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.kind == KIND_CLEAR) ? S_DONE : S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = (head_cur >= LINK_END) ? S_RESOLVE : S_CMP;
            end
            S_CMP:
            begin
                if (key_match || next_rdata >= LINK_END)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (kind_reg == KIND_PUT && !hit_reg && used_reg < LINK_END)
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ALLOC:
            begin
                state_next = S_LINK;
            end
            S_LINK:
            begin
                state_next = S_LINK2;
            end
            S_LINK2:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ent_re     = 1'b0;
        kv_we      = 1'b0;
        val_we     = 1'b0;
        val_waddr  = e_comb;
        next_we    = 1'b0;
        next_waddr = e_comb;
        next_wdata = LINK_END;
        head_we    = 1'b0;
        head_wdata = nx_reg;
        free_we    = 1'b0;
        free_waddr = IW'(used_reg - LW'(1));
        unique case (state_reg)
            S_HEAD:
            begin
                ent_re = head_cur < LINK_END;
            end
            S_CMP:
            begin
                ent_re = !key_match && (next_rdata < LINK_END);
            end
            S_RESOLVE:
            begin
                if (kind_reg == KIND_PUT && hit_reg)
                begin
                    val_we    = 1'b1;
                    val_waddr = cur_reg[IW-1:0];
                end
                if (rm_hit)
                begin
                    free_we = used_reg != '0;
                    if (prev_reg < LINK_END)
                    begin
                        next_we    = 1'b1;
                        next_waddr = prev_reg[IW-1:0];
                        next_wdata = nx_reg;
                    end
                    else
                    begin
                        head_we = 1'b1;
                    end
                end
            end
            S_LINK:
            begin
                kv_we   = 1'b1;
                val_we  = 1'b1;
                next_we = 1'b1;
            end
            S_LINK2:
            begin
                head_wdata = LW'(e_reg);
                if (prev_reg < LINK_END)
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_reg[IW-1:0];
                    next_wdata = LW'(e_reg);
                end
                else
                begin
                    head_we = 1'b1;
                end
            end
            default:
            begin
                ent_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bcount_reg    <= DIVISOR_RESET;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < BUCKETS; i++)
            begin
                head_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < ENTRIES; i++)
            begin
                free_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                bcount_reg <= cfg_data;
            end
            if (accept && req.kind == KIND_CLEAR)
            begin
                used_reg <= '0;
                for (int i = 0; i < BUCKETS; i++)
                begin
                    head_valid_reg[i] <= 1'b0;
                end
                for (int i = 0; i < ENTRIES; i++)
                begin
                    free_valid_reg[i] <= 1'b0;
                end
            end
            if (head_we)
            begin
                head_valid_reg[bucket_reg] <= 1'b1;
            end
            if (free_we)
            begin
                free_valid_reg[free_waddr] <= 1'b1;
                used_reg <= used_reg - LW'(1);
            end
            if (state_reg == S_LINK2)
            begin
                used_reg <= used_reg + LW'(1);
            end
            if (state_reg == S_DONE && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                kind_reg  <= req.kind;
                key_reg   <= req.key;
                value_reg <= req.value;
                hit_reg   <= 1'b0;
                ok_reg    <= req.kind == KIND_CLEAR;
                got_reg   <= '0;
                prev_reg  <= LINK_END;
            end
            S_HASH:
            begin
                bucket_reg <= hash_bucket;
            end
            S_HEAD:
            begin
                cur_reg <= head_cur;
            end
            S_CMP:
            begin
                if (key_match)
                begin
                    hit_reg <= 1'b1;
                    nx_reg  <= next_rdata;
                    if (kind_reg == KIND_GET)
                    begin
                        got_reg <= value_rdata;
                    end
                end
                else
                begin
                    prev_reg <= cur_reg;
                    cur_reg  <= next_rdata;
                end
            end
            S_RESOLVE:
            begin
                ok_reg <= hit_reg || (kind_reg == KIND_PUT && used_reg < LINK_END);
            end
            S_LINK:
            begin
                e_reg <= e_comb;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_reg.ok          <= ok_reg;
                    rsp_reg.found_value <= got_reg;
                    rsp_reg.entry_total <= used_wide[8:0];
                end
            end
            default:
            begin
                e_reg <= e_reg;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= LINK_END)
        else $error("entry count above pool size");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.kind == KIND_CLEAR |=> used_reg == '0)
        else $error("clear left entries counted");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> cur_reg < LINK_END)
        else $error("chain walk past end marker");

    assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == S_HASH)
        else $error("hash result outside hash wait");

endmodule
